FILE: hw/rtl/mtsha_pkg.sv
package mtsha_pkg;

	localparam int PasswordBytes = 125;
	localparam int UsernameBytes = 48;
	localparam int TableBytes    = 160;
	localparam int MsgBytes      = 384;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BUILD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_DERIVE,
		ST_EMIT
	} state_t;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	function automatic logic [7:0] table_byte(input logic [7:0] idx);
		logic [7:0] t [0:159];
		logic [7:0] r;
		t = '{
		8'h91,8'hAC,8'h51,8'h14,8'h9F,8'h67,8'h54,8'h43,8'h24,8'hE7,8'h3B,8'hE0,8'h28,8'h74,8'h7B,8'hC2,
		8'h86,8'h33,8'h13,8'hEB,8'h5A,8'h4F,8'hCB,8'h5C,8'h08,8'h0A,8'h73,8'h37,8'h0E,8'h5D,8'h1C,8'h2F,
		8'h33,8'h8F,8'hE6,8'hE5,8'hF8,8'h9B,8'hAE,8'hDD,8'h16,8'hF2,8'h4B,8'h8D,8'h2C,8'hE1,8'hD4,8'hDC,
		8'hB0,8'hCB,8'hDF,8'h9D,8'hD4,8'h70,8'h6D,8'h17,8'hF9,8'h4D,8'h42,8'h3F,8'h9B,8'h1B,8'h11,8'h94,
		8'h9F,8'h5B,8'hC1,8'h9B,8'h06,8'h05,8'h9D,8'h03,8'h9D,8'h5E,8'h13,8'h8A,8'h1E,8'h9A,8'h6A,8'hE8,
		8'hD9,8'h7C,8'h14,8'h17,8'h58,8'hC7,8'h2A,8'hF6,8'hA1,8'h99,8'h63,8'h0A,8'hD7,8'hFD,8'h70,8'hC3,
		8'hF6,8'h5E,8'h74,8'h13,8'h03,8'hC9,8'h0B,8'h04,8'h26,8'h98,8'hF7,8'h26,8'h8A,8'h92,8'h93,8'h25,
		8'hB0,8'hA2,8'h0D,8'h23,8'hED,8'h63,8'h79,8'h6D,8'h13,8'h32,8'hFA,8'h3C,8'h35,8'h02,8'h9A,8'hA3,
		8'hB3,8'hDD,8'h8E,8'h0A,8'h24,8'hBF,8'h51,8'hC3,8'h7C,8'hCD,8'h55,8'h9F,8'h37,8'hAF,8'h94,8'h4C,
		8'h29,8'h08,8'h52,8'h82,8'hB2,8'h3B,8'h4E,8'h37,8'h9F,8'h17,8'h07,8'h91,8'h11,8'h3B,8'hFD,8'hCD};
		r = (idx < 8'(TableBytes)) ? t[idx] : 8'h00;
		return r;
	endfunction

endpackage

FILE: hw/rtl/mtsha_round.sv
// One SHA-1 round per cycle while step is high; schedule kept in a 16-word shift window.
module mtsha_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init,
	input  logic        load_w,
	input  logic [31:0] load_word,
	input  logic        step,
	input  logic [6:0]  rnd,
	input  logic        chain_reset,
	input  logic        chain_add,
	output logic [31:0] chain [5]
);
	import mtsha_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] f, k, wt, wn, tmp;

	assign wn = {w_q[13][31:0] ^ w_q[8] ^ w_q[2] ^ w_q[0]};
	always_comb begin
		wt = (rnd < 7'd16) ? w_q[0] : {wn[30:0], wn[31]};
		if (rnd < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	always_ff @(posedge clk) begin
		if (load_w) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= load_word;
		end else if (step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
		if (init) begin
			a_q <= chain[0]; b_q <= chain[1]; c_q <= chain[2];
			d_q <= chain[3]; e_q <= chain[4];
		end else if (step) begin
			a_q <= tmp; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q; e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= H0; chain[1] <= H1; chain[2] <= H2; chain[3] <= H3; chain[4] <= H4;
		end else if (chain_reset) begin
			chain[0] <= H0; chain[1] <= H1; chain[2] <= H2; chain[3] <= H3; chain[4] <= H4;
		end else if (chain_add) begin
			chain[0] <= chain[0] + a_q; chain[1] <= chain[1] + b_q;
			chain[2] <= chain[2] + c_q; chain[3] <= chain[3] + d_q;
			chain[4] <= chain[4] + e_q;
		end
	end
endmodule

FILE: hw/rtl/magic_table_double_sha1_passcode.sv
// Double SHA-1 passcode hash unit.
// Input channel (in_valid/in_ready): one byte per item, password bytes first
// (is_username low), then user-name bytes; final_byte marks the last item.
// Non-final items are accepted and produce nothing.
// A final item starts two SHA-1 passes on one shared round unit. Each pass
// first assembles its whole padded message into the word memory, one byte a
// cycle; each 64-byte block then loads the schedule, runs 80 rounds and adds.
// Blocks per pass: up to three in the first pass, up to five in the second.
// The five result words then leave on out_valid/out_ready, word_index 0..4,
// one per cycle while out_ready is high, last_word on the fifth;
// input_truncated reports dropped bytes.
// in_ready stays low from the final item until the fifth word is taken.
// A stalled receiver simply holds the current word; nothing is lost.
// Reset clears counts, flags and the sequencer; the byte stores keep no
// reset value and are read only where written.
module magic_table_double_sha1_passcode #(
	parameter int PASSWORD_BYTES = mtsha_pkg::PasswordBytes,
	parameter int USERNAME_BYTES = mtsha_pkg::UsernameBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        is_username,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        input_truncated
);
	import mtsha_pkg::*;

	localparam int PW = $clog2(PASSWORD_BYTES + 1);
	localparam int UW = $clog2(USERNAME_BYTES + 1);

	state_t state_q, state_d;
	logic [7:0] pw_mem [PASSWORD_BYTES];
	logic [7:0] un_mem [USERNAME_BYTES];
	logic [31:0] msg_mem [MsgBytes/4];
	logic [PW-1:0] pcnt_q, tcnt_q;
	logic [UW-1:0] ucnt_q;
	logic ovf_q, pass_q;
	logic [8:0] pos_q, mlen_q, blen_q;
	logic [2:0] nblk_q, blk_q;
	logic [6:0] rnd_q;
	logic [6:0] len_q, off_q;
	logic [4:0] dcnt_q;
	logic [2:0] widx_q;
	logic [31:0] chain [5];
	logic [7:0] dbyte;
	logic [5:0] q6;
	logic [2:0] r6;
	logic [8:0] plen, ulen, tlen, mlen;
	logic [2:0] nblk;
	logic accept, init, load_w, step, ch_rst, ch_add;
	logic [PW-1:0] pw_addr;
	logic [UW-1:0] un_addr;
	logic sel_pw, sel_un;
	logic [7:0] const_byte, build_byte;
	logic [7:0] pw_rd_s1, un_rd_s1, cbyte_s1;
	logic use_pw_s1, use_un_s1, wr_s1;
	logic [8:0] pos_s1;
	logic [31:0] pack_q, msg_word_q;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign plen = 9'(tcnt_q);
	assign ulen = 9'(ucnt_q);
	assign tlen = pass_q ? 9'(len_q) : 9'd0;
	assign mlen = plen + tlen + ulen;
	assign nblk = 3'((mlen + 9'd8) >> 6) + 3'd1;

	// Pick the source of the message byte at pos_q; store reads land in the next cycle.
	always_comb begin
		logic [8:0] ui, ti;
		ui = pos_q - plen - tlen;
		ti = pos_q - plen + 9'(off_q);
		pw_addr = (pos_q < 9'(PASSWORD_BYTES)) ? pos_q[PW-1:0] : '0;
		un_addr = (ui < 9'(USERNAME_BYTES)) ? ui[UW-1:0] : '0;
		sel_pw = (pos_q < plen);
		sel_un = (pos_q >= plen + tlen) && (pos_q < mlen_q);
		if (pos_q >= plen && pos_q < plen + tlen) const_byte = table_byte(ti[7:0]);
		else if (pos_q == mlen_q) const_byte = 8'h80;
		else if (pos_q == blen_q - 9'd2) const_byte = {4'd0, mlen_q[8:5]};
		else if (pos_q == blen_q - 9'd1) const_byte = {mlen_q[4:0], 3'b000};
		else const_byte = 8'h00;
	end

	assign build_byte = use_pw_s1 ? pw_rd_s1 : (use_un_s1 ? un_rd_s1 : cbyte_s1);

	assign dbyte = 8'(chain[dcnt_q[4:2]] >> (5'd24 - {dcnt_q[1:0], 3'd0}));
	// byte mod 6 by reciprocal multiplication, exact over the whole byte range
	assign q6 = 6'(({8'd0, dbyte} * 16'd171) >> 10);
	assign r6 = 3'(dbyte - {q6, 2'b00} - {1'b0, q6, 1'b0});

	always_ff @(posedge clk) begin
		pw_rd_s1 <= pw_mem[pw_addr];
		un_rd_s1 <= un_mem[un_addr];
		cbyte_s1 <= const_byte;
		use_pw_s1 <= sel_pw;
		use_un_s1 <= sel_un;
		pos_s1 <= pos_q;
		msg_word_q <= msg_mem[{blk_q, rnd_q[3:0]}];
		// pack four bytes, then write the whole word
		if (wr_s1) begin
			pack_q <= {pack_q[23:0], build_byte};
			if (pos_s1[1:0] == 2'd3) msg_mem[pos_s1[8:2]] <= {pack_q[23:0], build_byte};
		end
		if (accept && !is_username && pcnt_q < PW'(PASSWORD_BYTES)) pw_mem[pcnt_q] <= data_byte;
		if (accept && is_username && ucnt_q < UW'(USERNAME_BYTES)) un_mem[ucnt_q] <= data_byte;
	end

	mtsha_round u_round (
		.clk, .arst_n, .init, .load_w,
		.load_word(msg_word_q), .step, .rnd(rnd_q),
		.chain_reset(ch_rst), .chain_add(ch_add), .chain
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && final_byte) state_d = ST_CLEAR;
			ST_CLEAR:  state_d = ST_BUILD;
			ST_BUILD:  if (pos_q == blen_q - 9'd1) state_d = ST_LOAD;
			ST_LOAD:   if (rnd_q == 7'd16) state_d = ST_ROUND;
			ST_ROUND:  if (rnd_q == 7'd79) state_d = ST_ADD;
			ST_ADD: begin
				if (blk_q != nblk_q - 3'd1) state_d = ST_LOAD;
				else if (!pass_q) state_d = ST_DERIVE;
				else state_d = ST_EMIT;
			end
			ST_DERIVE: if (dcnt_q == 5'd19) state_d = ST_CLEAR;
			ST_EMIT:   if (out_ready && widx_q == 3'd4) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		init = (state_q == ST_LOAD) && (rnd_q == 7'd0);
		load_w = (state_q == ST_LOAD) && (rnd_q != 7'd0);
		step = (state_q == ST_ROUND);
		ch_rst = (state_q == ST_CLEAR);
		ch_add = (state_q == ST_ADD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pcnt_q <= '0; tcnt_q <= '0; ucnt_q <= '0; ovf_q <= 1'b0; pass_q <= 1'b0;
			pos_q <= '0; rnd_q <= '0; blk_q <= '0; dcnt_q <= '0; widx_q <= '0;
			mlen_q <= '0; nblk_q <= '0; blen_q <= '0; len_q <= '0; off_q <= '0;
			wr_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_s1 <= (state_q == ST_BUILD);
			if (accept) begin
				if (is_username) begin
					if (ucnt_q < UW'(USERNAME_BYTES)) ucnt_q <= ucnt_q + UW'(1);
					else ovf_q <= 1'b1;
				end else if (pcnt_q < PW'(PASSWORD_BYTES)) begin
					pcnt_q <= pcnt_q + PW'(1);
					if (data_byte != 8'h20) tcnt_q <= pcnt_q + PW'(1);
				end else ovf_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					pos_q <= '0; blk_q <= '0;
					mlen_q <= mlen; nblk_q <= nblk; blen_q <= {nblk, 6'd0};
				end
				ST_BUILD: begin
					pos_q <= pos_q + 9'd1;
					rnd_q <= '0;
				end
				ST_LOAD:  rnd_q <= (rnd_q == 7'd16) ? 7'd0 : rnd_q + 7'd1;
				ST_ROUND: rnd_q <= (rnd_q == 7'd79) ? 7'd0 : rnd_q + 7'd1;
				ST_ADD: begin
					rnd_q <= '0; blk_q <= blk_q + 3'd1;
					if (blk_q == nblk_q - 3'd1 && !pass_q) begin
						dcnt_q <= '0; len_q <= 7'h20; off_q <= '0;
					end
				end
				ST_DERIVE: begin
					if (dcnt_q < 5'd10) len_q <= len_q + 7'(r6);
					else off_q <= off_q + 7'(dbyte[2:0]);
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd19) pass_q <= 1'b1;
				end
				ST_EMIT: if (out_ready) begin
					if (widx_q == 3'd4) begin
						widx_q <= '0; pass_q <= 1'b0; pcnt_q <= '0; tcnt_q <= '0;
						ucnt_q <= '0; ovf_q <= 1'b0;
					end else begin
						widx_q <= widx_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = (state_q == ST_EMIT);
	assign digest_word = chain[widx_q];
	assign word_index = widx_q;
	assign last_word = (widx_q == 3'd4);
	assign input_truncated = ovf_q;
endmodule

FILE: hw/rtl/mtsha_checker.sv
module mtsha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while results pending");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd4))) else $error("last_word mismatch");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
		else $error("word order broken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)) else $error("stall lost word");
endmodule

bind magic_table_double_sha1_passcode mtsha_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.digest_word, .word_index, .last_word
);
